/* hdl/pdid_pkg.sv */
package pdid_pkg;

  // Default width of the internal position counters
  localparam int unsigned POS_WIDTH_DEF = 32;

  localparam int unsigned COPY_LEN_W = 17;
  localparam logic [24:0] COPY_MAX   = 25'h10000;

  typedef enum logic [1:0] {
    REC_LITERAL    = 2'd0,
    REC_COPY       = 2'd1,
    REC_FINISH_OK  = 2'd2,
    REC_FINISH_BAD = 2'd3
  } rec_kind_e;

  typedef enum logic [2:0] {
    PH_SRC   = 3'd0,
    PH_TGT   = 3'd1,
    PH_CMD   = 3'd2,
    PH_PARAM = 3'd3,
    PH_LIT   = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0] delta_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    rec_kind_e               record_kind;
    logic [7:0]              literal_value;
    logic [31:0]             copy_offset;
    logic [COPY_LEN_W-1:0]   copy_length;
    logic [31:0]             write_position;
    logic [31:0]             result_length;
    logic                    last_of_run;
  } out_beat_t;

endpackage

/* hdl/pack_delta_instruction_decoder.sv */
// Delta instruction decoder for packed object streams.
// Input channel (in_valid_i / in_stall_o / in_data_i): one delta byte per beat,
// with last_byte set on the final byte of a stream. Output channel
// (out_valid_o / out_stall_i / out_data_o): literal, copy and finish records.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the base object
// length; write it only while no stream is in flight.
// Each input beat is decoded in the cycle it is accepted: the header sizes,
// command state and bounds checks are updated and up to two records (a literal
// or copy, plus a finish record on the last byte) are pushed into a 4-entry
// output queue. A record that enters an empty queue is visible on out_data_o
// the cycle after its input beat is accepted.
// Throughput: one input beat per cycle while in_stall_o is low and one output
// beat per cycle while out_stall_i is low. The queue accepts a new input beat
// while it holds at most two records; a two-record byte takes two output beats.
// When the receiver stalls, the head record holds and the queue fills; once
// it holds three records in_stall_o is raised until beats drain.
// Reset clears the base length, the decoder state and the queue; the decoder
// also restarts on its own after each last byte.
module pack_delta_instruction_decoder
  import pdid_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = POS_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_beat_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_beat_t  out_data_o
);

  localparam int unsigned P    = POSITION_WIDTH;
  // sum width for bounds checks against a 25-bit copy size
  localparam int unsigned SUMW = ((P > 25) ? P : 25) + 1;
  localparam int unsigned EXTW = 70;  // 7 payload bits shifted up to 63
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  function automatic logic [31:0] pos32(input logic [P-1:0] x);
    logic [63:0] t;
    t = '0;
    t[P-1:0] = x;
    return t[31:0];
  endfunction

  // ---------------------------------------------------------------------
  // State
  logic [31:0]  base_bytes_q;
  phase_e       phase_q, phase_d;
  logic [P-1:0] acc_q, acc_d;
  logic [5:0]   shift_q, shift_d;
  logic [P-1:0] target_q, target_d;
  logic [6:0]   flags_q, flags_d;
  logic [31:0]  off_q, off_d;
  logic [23:0]  size_q, size_d;
  logic [6:0]   lit_left_q, lit_left_d;
  logic [P-1:0] wcount_q, wcount_d;
  logic         corrupt_q, corrupt_d;

  logic         accept;
  logic [7:0]   b;
  logic         last;

  assign accept = in_valid_i && !in_stall_o;
  assign b      = in_data_i.delta_byte;
  assign last   = in_data_i.last_byte;

  // records produced by this beat
  out_beat_t    rec_a, rec_b;
  logic         rec_a_vld, rec_b_vld;

  logic [EXTW-1:0] ext;
  logic [2:0]      idx;
  logic            fin_copy;
  logic [24:0]     csize;
  logic            too_long, base_ovr, tgt_ovr;

  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    shift_d    = shift_q;
    target_d   = target_q;
    flags_d    = flags_q;
    off_d      = off_q;
    size_d     = size_q;
    lit_left_d = lit_left_q;
    wcount_d   = wcount_q;
    corrupt_d  = corrupt_q;
    rec_a      = '0;
    rec_b      = '0;
    rec_a_vld  = 1'b0;
    rec_b_vld  = 1'b0;
    ext        = '0;
    idx        = 3'd7;
    fin_copy   = 1'b0;
    csize      = '0;
    too_long   = 1'b0;
    base_ovr   = 1'b0;
    tgt_ovr    = 1'b0;

    if (accept) begin
      if (!corrupt_q) begin
        case (phase_q)
          PH_SRC, PH_TGT: begin
            // base-128 size digit; saturate on anything past P bits
            ext = EXTW'(b[6:0]) << shift_q;
            if (|(ext >> P)) begin
              acc_d = '1;
            end else begin
              acc_d = acc_q | ext[P-1:0];
            end
            shift_d = (shift_q > 6'd56) ? 6'd63 : shift_q + 6'd7;
            if (!b[7]) begin
              if (phase_q == PH_TGT) begin
                target_d = acc_d;
                phase_d  = PH_CMD;
              end else begin
                phase_d  = PH_TGT;
              end
              acc_d   = '0;
              shift_d = '0;
            end
          end
          PH_CMD: begin
            if (b[7]) begin
              flags_d = b[6:0];
              off_d   = '0;
              size_d  = '0;
              if (b[6:0] == 7'd0) begin
                fin_copy = 1'b1;
              end else begin
                phase_d = PH_PARAM;
              end
            end else if (b != 8'd0) begin
              if ((SUMW'(wcount_q) + SUMW'(b[6:0])) > SUMW'(target_q)) begin
                corrupt_d = 1'b1;
              end else begin
                lit_left_d = b[6:0];
                phase_d    = PH_LIT;
              end
            end
          end
          PH_PARAM: begin
            // lowest pending flag selects which parameter byte this is
            for (int i = 6; i >= 0; i--) begin
              if (flags_q[i]) idx = 3'(i);
            end
            if (idx < 3'd4) begin
              off_d = off_q | (32'(b) << {idx[1:0], 3'b000});
            end else if (idx < 3'd7) begin
              size_d = size_q | (24'(b) << {idx[1:0], 3'b000});
            end
            flags_d = flags_q & (flags_q - 7'd1);
            if (flags_d == 7'd0) fin_copy = 1'b1;
          end
          PH_LIT: begin
            rec_a_vld            = 1'b1;
            rec_a.record_kind    = REC_LITERAL;
            rec_a.literal_value  = b;
            rec_a.write_position = pos32(wcount_q);
            wcount_d             = wcount_q + P'(1);
            lit_left_d           = lit_left_q - 7'd1;
            if (lit_left_d == 7'd0) phase_d = PH_CMD;
          end
          default: begin
            phase_d = PH_CMD;
          end
        endcase

        if (fin_copy) begin
          phase_d  = PH_CMD;
          csize    = (size_d == 24'd0) ? COPY_MAX : {1'b0, size_d};
          too_long = csize > COPY_MAX;
          base_ovr = ({2'b00, off_d} + 34'(csize)) > {2'b00, base_bytes_q};
          tgt_ovr  = (SUMW'(wcount_q) + SUMW'(csize)) > SUMW'(target_q);
          if (too_long || base_ovr || tgt_ovr) begin
            corrupt_d = 1'b1;
          end else begin
            rec_a_vld            = 1'b1;
            rec_a.record_kind    = REC_COPY;
            rec_a.copy_offset    = off_d;
            rec_a.copy_length    = csize[COPY_LEN_W-1:0];
            rec_a.write_position = pos32(wcount_q);
            wcount_d             = wcount_q + P'(csize);
          end
        end
      end

      if (last) begin
        // ending inside copy params or literals is a truncation
        if (!corrupt_d && (phase_d == PH_PARAM || phase_d == PH_LIT)) corrupt_d = 1'b1;
        rec_b_vld           = 1'b1;
        rec_b.record_kind   = corrupt_d ? REC_FINISH_BAD : REC_FINISH_OK;
        rec_b.result_length = pos32(wcount_d);
        rec_b.last_of_run   = 1'b1;
        phase_d    = PH_SRC;
        acc_d      = '0;
        shift_d    = '0;
        target_d   = '0;
        flags_d    = '0;
        off_d      = '0;
        size_d     = '0;
        lit_left_d = '0;
        wcount_d   = '0;
        corrupt_d  = 1'b0;
      end
      rec_a.last_of_run = !rec_b_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_bytes_q <= '0;
      phase_q    <= PH_SRC;
      acc_q      <= '0;
      shift_q    <= '0;
      target_q   <= '0;
      flags_q    <= '0;
      off_q      <= '0;
      size_q     <= '0;
      lit_left_q <= '0;
      wcount_q   <= '0;
      corrupt_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) base_bytes_q <= cfg_data_i;
      phase_q    <= phase_d;
      acc_q      <= acc_d;
      shift_q    <= shift_d;
      target_q   <= target_d;
      flags_q    <= flags_d;
      off_q      <= off_d;
      size_q     <= size_d;
      lit_left_q <= lit_left_d;
      wcount_q   <= wcount_d;
      corrupt_q  <= corrupt_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------
  // Output queue
  out_beat_t          q_mem [QDEPTH];
  logic [QAW-1:0]     head_q, tail_q;
  logic [QAW:0]       count_q;
  logic [1:0]         n_push;
  logic               pop;
  out_beat_t          push0, push1;

  assign n_push = 2'(rec_a_vld) + 2'(rec_b_vld);
  assign push0  = rec_a_vld ? rec_a : rec_b;
  assign push1  = rec_b;
  assign pop    = out_valid_o && !out_stall_i;

  // room for two records is kept for every accepted beat
  assign in_stall_o  = count_q > (QAW+1)'(QDEPTH - 2);
  assign out_valid_o = count_q != '0;
  assign out_data_o  = q_mem[head_q];

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) q_mem[tail_q] <= push0;
    if (n_push == 2'd2) q_mem[tail_q + QAW'(1)] <= push1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      tail_q  <= tail_q + QAW'(n_push);
      if (pop) head_q <= head_q + QAW'(1);
      count_q <= count_q + (QAW+1)'(n_push) - (QAW+1)'(pop);
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QAW+1)'(QDEPTH))
    else $error("output queue overfilled");

  a_wcount_in_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcount_q <= target_q)
    else $error("write count passed target size");

  a_copy_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_a_vld && rec_a.record_kind == REC_COPY) |->
      (rec_a.copy_length != '0 && rec_a.copy_length <= COPY_MAX[COPY_LEN_W-1:0]))
    else $error("copy length out of range");

  a_no_rec_when_corrupt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    corrupt_q |-> !rec_a_vld)
    else $error("record emitted after corruption");

  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> (phase_q == PH_SRC && wcount_q == '0 && !corrupt_q))
    else $error("stream state not cleared after last byte");

  a_param_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PARAM) |-> (flags_q != 7'd0))
    else $error("parameter phase with no pending flags");

endmodule

/* dv/delta_record_checker.sv */
module delta_record_checker
  import pdid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_beat_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_beat_t   out_data_i,
  output int          fail_count_o,
  output int          records_pending_o
);

  localparam logic [63:0] POS_ALL_ONES = 64'hFFFF_FFFF;
  localparam int unsigned MAX_PRINTED  = 100;

  // Decoder shadow state, positions kept wide so sums never wrap
  logic [63:0] base_bytes;
  phase_e      phase;
  logic [63:0] size_acc;
  int          size_shift;
  logic [63:0] target_bytes;
  logic [6:0]  param_flags;
  logic [63:0] off_work;
  logic [63:0] size_work;
  logic [6:0]  lits_left;
  logic [63:0] written;
  logic        corrupt;

  out_beat_t decoded_records[$];

  task automatic restart_stream();
    phase        = PH_SRC;
    size_acc     = '0;
    size_shift   = 0;
    target_bytes = '0;
    param_flags  = '0;
    off_work     = '0;
    size_work    = '0;
    lits_left    = '0;
    written      = '0;
    corrupt      = 1'b0;
  endtask

  task automatic add_record(rec_kind_e kind, logic [7:0] lit, logic [63:0] off,
                            logic [63:0] len, logic [63:0] wp, logic [63:0] rl);
    out_beat_t r;
    r.record_kind    = kind;
    r.literal_value  = lit;
    r.copy_offset    = off[31:0];
    r.copy_length    = len[COPY_LEN_W-1:0];
    r.write_position = wp[31:0];
    r.result_length  = rl[31:0];
    r.last_of_run    = 1'b0;
    decoded_records.push_back(r);
  endtask

  // Base-128 size digit; anything past 32 bits pins the size at all ones
  task automatic take_size_byte(logic [7:0] b);
    logic [63:0] bits;
    logic [63:0] chunk;
    bits  = {57'b0, b[6:0]};
    chunk = bits << size_shift;
    if ((chunk >> size_shift) != bits || chunk > POS_ALL_ONES) size_acc = POS_ALL_ONES;
    else size_acc = size_acc | chunk;
    size_shift = (size_shift + 7 > 63) ? 63 : size_shift + 7;
  endtask

  task automatic close_copy();
    logic [63:0] sz;
    sz    = (size_work != 0) ? size_work : 64'(COPY_MAX);
    phase = PH_CMD;
    if (sz > 64'(COPY_MAX) || off_work + sz > base_bytes || written + sz > target_bytes) begin
      corrupt = 1'b1;
    end else begin
      add_record(REC_COPY, 8'h00, off_work, sz, written, '0);
      written = written + sz;
    end
  endtask

  task automatic decode_delta_byte(in_beat_t beat);
    logic [7:0] b;
    int         prior;
    int         i;
    out_beat_t  tail;
    b     = beat.delta_byte;
    prior = decoded_records.size();
    if (!corrupt) begin
      case (phase)
        PH_SRC, PH_TGT: begin
          take_size_byte(b);
          if (!b[7]) begin
            if (phase == PH_TGT) begin
              target_bytes = size_acc;
              phase        = PH_CMD;
            end else begin
              phase = PH_TGT;
            end
            size_acc   = '0;
            size_shift = 0;
          end
        end
        PH_CMD: begin
          if (b[7]) begin
            param_flags = b[6:0];
            off_work    = '0;
            size_work   = '0;
            if (param_flags == 0) close_copy();
            else phase = PH_PARAM;
          end else if (b != 0) begin
            if (written + b > target_bytes) begin
              corrupt = 1'b1;
            end else begin
              lits_left = b[6:0];
              phase     = PH_LIT;
            end
          end
        end
        PH_PARAM: begin
          i = 0;
          while (i < 7 && !param_flags[i]) i++;
          if (i < 4) off_work = off_work | ({56'b0, b} << (8 * i));
          else if (i < 7) size_work = size_work | ({56'b0, b} << (8 * (i - 4)));
          if (i < 7) param_flags[i] = 1'b0;
          if (param_flags == 0) close_copy();
        end
        PH_LIT: begin
          add_record(REC_LITERAL, b, '0, '0, written, '0);
          written = written + 1;
          if (lits_left > 0) lits_left = lits_left - 1;
          if (lits_left == 0) phase = PH_CMD;
        end
        default: phase = PH_CMD;
      endcase
    end
    if (beat.last_byte) begin
      // ending inside copy params or literals is a truncated stream
      if (!corrupt && (phase == PH_PARAM || phase == PH_LIT)) corrupt = 1'b1;
      add_record(corrupt ? REC_FINISH_BAD : REC_FINISH_OK, 8'h00, '0, '0, '0, written);
      restart_stream();
    end
    if (decoded_records.size() > prior) begin
      tail = decoded_records.pop_back();
      tail.last_of_run = 1'b1;
      decoded_records.push_back(tail);
    end
  endtask

  task automatic report_mismatch(string what, longint unsigned seen, longint unsigned wanted);
    if (fail_count_o < MAX_PRINTED)
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, seen, wanted);
    fail_count_o++;
  endtask

  task automatic compare_record(out_beat_t got);
    out_beat_t want;
    if (decoded_records.size() == 0) begin
      report_mismatch("record with nothing outstanding, kind", got.record_kind, 0);
      return;
    end
    want = decoded_records.pop_front();
    if (got.record_kind !== want.record_kind)
      report_mismatch("record_kind", got.record_kind, want.record_kind);
    if (got.literal_value !== want.literal_value)
      report_mismatch("literal_value", got.literal_value, want.literal_value);
    if (got.copy_offset !== want.copy_offset)
      report_mismatch("copy_offset", got.copy_offset, want.copy_offset);
    if (got.copy_length !== want.copy_length)
      report_mismatch("copy_length", got.copy_length, want.copy_length);
    if (got.write_position !== want.write_position)
      report_mismatch("write_position", got.write_position, want.write_position);
    if (got.result_length !== want.result_length)
      report_mismatch("result_length", got.result_length, want.result_length);
    if (got.last_of_run !== want.last_of_run)
      report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_bytes = '0;
      restart_stream();
      decoded_records.delete();
      fail_count_o      = 0;
      records_pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) base_bytes = {32'b0, cfg_data_i};
      if (in_valid_i && !in_stall_i) decode_delta_byte(in_data_i);
      if (out_valid_i && !out_stall_i) compare_record(out_data_i);
      records_pending_o = decoded_records.size();
    end
  end

endmodule

/* dv/tb_top.sv */
module tb_top;
  import pdid_pkg::*;

  // Random part length in delta bytes, on top of the directed streams
  localparam int unsigned ITEM_TARGET  = 1750;
  // Cycles without any beat on any channel before the run is declared hung.
  // Longest legal quiet stretch is the long receiver hold-off (CHOKE_CYCLES).
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned CHOKE_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_data;
  int          fail_count;
  int          records_pending;

  bit          calm;        // no idling on either side while set
  bit          choke_req;   // receiver takes one long hold-off when set
  int unsigned items_sent;
  logic [31:0] base_now;    // base length currently programmed
  logic [7:0]  stream_q[$]; // bytes of the stream being built

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  pack_delta_instruction_decoder dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  delta_record_checker u_chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .fail_count_o     (fail_count),
    .records_pending_o(records_pending)
  );

  // ---------------------------------------------------------------------
  // Channel drivers. All start at a falling edge; those that return do so at one.
  // ---------------------------------------------------------------------

  // One delta byte: optional gap with valid low, then hold until accepted.
  task automatic send_delta_byte(logic [7:0] b, logic fin);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, fin};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // Receiver: random stall before each record, plus the long hold-off on
  // request so the output queue fills and the block stalls its input.
  task automatic drain_records();
    int hold;
    forever begin
      if (choke_req) begin
        choke_req = 1'b0;
        hold      = CHOKE_CYCLES;
      end else begin
        hold = calm ? 0 : $urandom_range(0, 7);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  endtask

  // Register writes happen only with the block drained: no record owed and
  // a few spare cycles for a byte that produced nothing.
  task automatic set_base_length(logic [31:0] v);
    in_valid <= 1'b0;
    while (records_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    base_now = v;
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) send_delta_byte(stream_q[i], i == stream_q.size() - 1);
    stream_q.delete();
  endtask

  // ---------------------------------------------------------------------
  // Stream builders
  // ---------------------------------------------------------------------

  task automatic put_varint(longint unsigned v);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) b[7] = 1'b1;
      stream_q.push_back(b);
    end while (v != 0);
  endtask

  // Copy command: nonzero param bytes always present, zero ones sometimes.
  // A 64 KiB copy is often sent with an all-zero size.
  task automatic put_copy(logic [31:0] off, longint unsigned sz);
    logic [7:0]  cmd;
    logic [23:0] zsz;
    logic [7:0]  params[$];
    zsz = (sz == 65536 && $urandom_range(0, 1)) ? 24'd0 : sz[23:0];
    cmd = 8'h80;
    for (int i = 0; i < 4; i++) begin
      if (off[8*i +: 8] != 0 || $urandom_range(0, 3) == 0) begin
        cmd[i] = 1'b1;
        params.push_back(off[8*i +: 8]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (zsz[8*i +: 8] != 0 || $urandom_range(0, 3) == 0) begin
        cmd[4+i] = 1'b1;
        params.push_back(zsz[8*i +: 8]);
      end
    end
    stream_q.push_back(cmd);
    foreach (params[i]) stream_q.push_back(params[i]);
  endtask

  // Legal stream: sizes, then inserts, copies within base and target, and
  // the odd zero command. Often stops short of the target size.
  task automatic write_clean_stream(logic [31:0] target);
    longint unsigned filled;
    longint unsigned rem;
    longint unsigned lim;
    longint unsigned sz;
    longint unsigned off;
    int              cmds;
    int              n;
    int              c;
    logic [7:0]      lit;
    put_varint($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 500));
    put_varint(target);
    filled = 0;
    cmds   = $urandom_range(0, 8);
    repeat (cmds) begin
      rem = target - filled;
      c   = $urandom_range(0, 9);
      if (c == 0) begin
        stream_q.push_back(8'h00);
      end else if (rem > 0 && (c < 6 || base_now == 0)) begin
        lim = (rem < 127) ? rem : 127;
        if ($urandom_range(0, 1) && lim > 16) lim = 16;
        n   = $urandom_range(1, 32'(lim));
        lit = n[7:0];
        stream_q.push_back(lit);
        repeat (n) begin
          lit = 8'($urandom_range(0, 255));
          stream_q.push_back(lit);
        end
        filled += n;
      end else if (rem > 0) begin
        lim = rem;
        if (lim > base_now) lim = base_now;
        if (lim > 65536) lim = 65536;
        sz  = ($urandom_range(0, 3) == 0) ? lim : $urandom_range(1, 32'(lim));
        // copies ending exactly at the end of the base object are common
        off = ($urandom_range(0, 3) == 0) ? base_now - sz
                                          : $urandom_range(0, 32'(base_now - sz));
        put_copy(off[31:0], sz);
        filled += sz;
      end
    end
  endtask

  // Broken stream: cut short anywhere, or a random command tacked on that
  // may overrun, be truncated or be fine.
  task automatic break_stream();
    int         cut;
    int         n;
    logic [7:0] lit;
    if ($urandom_range(0, 1)) begin
      cut = $urandom_range(1, stream_q.size());
      while (stream_q.size() > cut) stream_q.delete(stream_q.size() - 1);
    end else begin
      if ($urandom_range(0, 1)) lit = 8'($urandom_range(1, 127));
      else lit = 8'h80 | 8'($urandom_range(0, 127));
      stream_q.push_back(lit);
      n = $urandom_range(0, 8);
      repeat (n) begin
        lit = 8'($urandom_range(0, 255));
        stream_q.push_back(lit);
      end
    end
  endtask

  task automatic write_noise();
    int         n;
    logic [7:0] lit;
    n = $urandom_range(1, 40);
    repeat (n) begin
      lit = 8'($urandom_range(0, 255));
      stream_q.push_back(lit);
    end
  endtask

  function automatic logic [31:0] draw_target();
    int c;
    c = $urandom_range(0, 9);
    if (c < 6) return $urandom_range(0, 400);
    if (c < 9) return $urandom_range(0, 300000);
    return $urandom();
  endfunction

  // ---------------------------------------------------------------------
  // Watchdog: ends the run if no beat moves on any channel for too long.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("pack_delta_instruction_decoder test failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus and verdict
  // ---------------------------------------------------------------------
  initial begin
    int unsigned directed_items;
    int unsigned streams;
    int          pick;
    logic [7:0]  lit;

    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    calm       = 1'b0;
    choke_req  = 1'b0;
    items_sent = 0;
    base_now   = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    fork
      drain_records();
    join_none

    // Base length still at its reset value of zero. Zero command skipped,
    // insert with extreme literals, then an insert cut short inside its literals.
    stream_q = '{8'h05, 8'h0A, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h03, 8'hAA, 8'h55};
    send_stream();

    // Widest base. Source size overflows and saturates; target size uses all
    // 32 bits; a 64 KiB copy with zero size bytes; then a size byte that
    // makes the copy too long, and a byte ignored after the fault.
    set_base_length(32'hFFFF_FFFF);
    stream_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                 8'h80, 8'h80, 8'h80, 8'h80, 8'h0F,
                 8'hB0, 8'h00, 8'h00,
                 8'hC0, 8'h02, 8'h7F};
    send_stream();

    // Stream that ends while still reading the sizes
    set_base_length(32'h0);
    stream_q = '{8'h00};
    send_stream();

    directed_items = items_sent;
    streams        = 0;
    while (items_sent < directed_items + ITEM_TARGET) begin
      if (streams % 8 == 0) begin
        pick = $urandom_range(0, 4);
        case (pick)
          0: set_base_length(32'h0);
          1: set_base_length(32'hFFFF_FFFF);
          2: set_base_length($urandom_range(1, 400));
          3: set_base_length($urandom_range(1, 200000));
          default: set_base_length($urandom());
        endcase
      end
      calm = ($urandom_range(0, 4) == 0);
      if (streams == 12 || streams == 70) begin
        // long insert while the receiver holds off: queue fills, input stalls
        choke_req = 1'b1;
        put_varint(16);
        put_varint(120);
        stream_q.push_back(8'd120);
        repeat (120) begin
          lit = 8'($urandom_range(0, 255));
          stream_q.push_back(lit);
        end
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 17) write_clean_stream(draw_target());
        if (pick >= 14 && pick < 17) break_stream();
        else if (pick >= 17) write_noise();
      end
      send_stream();
      streams++;
    end

    in_valid <= 1'b0;
    while (records_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("pack_delta_instruction_decoder test passed");
    end else begin
      $display("pack_delta_instruction_decoder test failed");
    end
    $finish;
  end

endmodule
